@@ rtl/fnb_pkg.sv @@
// ============================================================================
// fnb_pkg
// Shared widths, register codes and helper types for the four-neighbor blur.
// ============================================================================
package fnb_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 10;   // width of a configuration register
  localparam int CFG_IDX_W  = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int SUM_W      = PIX_W + 2;
  localparam int AVG_SHIFT  = 2;
  localparam int OUTQ_DEPTH = 3;    // result queue entries; pointers are 2 bits

  localparam logic [DIM_W-1:0] LINE_WIDTH_RST   = DIM_W'(320);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(200);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Per-item control computed from the raster position
  typedef struct packed {
    logic             produce;    // item yields a result (not input row 0)
    logic             zero;       // result lies on the top or bottom row
    logic             frame_end;  // result is the last one of the frame
    logic [COL_W-1:0] col;        // column of this item
    logic [COL_W-1:0] rd_col;     // column of the raw right neighbor
  } item_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } result_t;

  function automatic logic [WID_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v < DIM_W'(2)) begin
      r = WID_W'(2);
    end else if (int'(v) > MAX_WIDTH) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v < DIM_W'(2)) begin
      r = ROW_W'(2);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = ROW_W'(MAX_HEIGHT);
    end else begin
      r = ROW_W'(v);
    end
    return r;
  endfunction

endpackage

@@ rtl/fnb_ifs.sv @@
// ============================================================================
// fnb channel interfaces
// Valid/ready channels for pixels in, results out and register writes.
// ============================================================================
interface fnb_pix_if;
  logic                      valid;
  logic                      ready;
  logic [fnb_pkg::PIX_W-1:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface fnb_res_if;
  logic                      valid;
  logic                      ready;
  logic [fnb_pkg::PIX_W-1:0] pixel_out;
  logic                      frame_end;
  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface fnb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fnb_pkg::CFG_IDX_W-1:0] index;
  logic [fnb_pkg::DIM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/fnb_ctrl.sv @@
// ============================================================================
// fnb_ctrl
// Configuration registers and raster position tracking.
// ============================================================================
module fnb_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fnb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fnb_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          accept,
  output fnb_pkg::item_ctl_t            ctl
);

  logic [fnb_pkg::DIM_W-1:0] line_width;
  logic [fnb_pkg::DIM_W-1:0] frame_height;
  logic [fnb_pkg::COL_W-1:0] col;
  logic [fnb_pkg::ROW_W-1:0] row;

  logic [fnb_pkg::WID_W-1:0] w_eff;
  logic [fnb_pkg::ROW_W-1:0] h_eff;
  logic                      last_col;
  logic                      last_row;

  assign w_eff    = fnb_pkg::clamp_width(line_width);
  assign h_eff    = fnb_pkg::clamp_height(frame_height);
  assign last_col = (fnb_pkg::WID_W'(col) == w_eff - fnb_pkg::WID_W'(1));
  assign last_row = (row == h_eff);

  always_comb begin
    ctl.produce   = (row != '0);
    ctl.zero      = (row == fnb_pkg::ROW_W'(1)) || last_row;
    ctl.frame_end = last_row && last_col;
    ctl.col       = col;
    ctl.rd_col    = last_col ? '0 : col + fnb_pkg::COL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= fnb_pkg::LINE_WIDTH_RST;
      frame_height <= fnb_pkg::FRAME_HEIGHT_RST;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      // a write to either configuration register restarts the frame
      if (cfg_idx == fnb_pkg::REG_LINE_WIDTH) begin
        line_width <= cfg_data;
        col        <= '0;
        row        <= '0;
      end else if (cfg_idx == fnb_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
        col          <= '0;
        row          <= '0;
      end
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + fnb_pkg::ROW_W'(1);
      end else begin
        col <= col + fnb_pkg::COL_W'(1);
      end
    end
  end

endmodule

@@ rtl/fnb_core.sv @@
// ============================================================================
// fnb_core
// Raw and blurred line memories with the read-modify-write averaging stage.
// ============================================================================
module fnb_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [fnb_pkg::PIX_W-1:0] pixel,
  input  fnb_pkg::item_ctl_t        ctl,
  output logic                      busy,
  output logic                      push,
  output fnb_pkg::result_t          result
);

  logic [fnb_pkg::PIX_W-1:0] raw_mem  [fnb_pkg::MAX_WIDTH];
  logic [fnb_pkg::PIX_W-1:0] blur_mem [fnb_pkg::MAX_WIDTH];

  logic [fnb_pkg::PIX_W-1:0] raw_rd;
  logic [fnb_pkg::PIX_W-1:0] blur_rd;
  logic                      s1_valid;
  fnb_pkg::item_ctl_t        s1_ctl;
  logic [fnb_pkg::PIX_W-1:0] s1_pix;
  logic [fnb_pkg::PIX_W-1:0] prev_blur;

  logic [fnb_pkg::SUM_W-1:0] sum;
  logic [fnb_pkg::PIX_W-1:0] value;

  // Consecutive items touch distinct columns (width is at least two), so the
  // blurred write of one item never meets the read of the next.
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_mem[ctl.col] <= pixel;
      raw_rd           <= raw_mem[ctl.rd_col];
      blur_rd          <= blur_mem[ctl.col];
      s1_ctl           <= ctl;
      s1_pix           <= pixel;
    end
    if (push) begin
      blur_mem[s1_ctl.col] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      prev_blur <= '0;
    end else begin
      s1_valid <= accept;
      if (push) begin
        prev_blur <= value;
      end
    end
  end

  assign sum = fnb_pkg::SUM_W'(prev_blur) + fnb_pkg::SUM_W'(raw_rd)
             + fnb_pkg::SUM_W'(blur_rd) + fnb_pkg::SUM_W'(s1_pix);
  assign value = s1_ctl.zero ? '0 : sum[fnb_pkg::SUM_W-1:fnb_pkg::AVG_SHIFT];

  assign busy             = s1_valid;
  assign push             = s1_valid && s1_ctl.produce;
  assign result.pixel     = value;
  assign result.frame_end = s1_ctl.frame_end;

endmodule

@@ rtl/fnb_outq.sv @@
// ============================================================================
// fnb_outq
// Three-entry result queue that decouples the output handshake.
// ============================================================================
module fnb_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fnb_pkg::result_t push_data,
  input  logic             inflight,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output fnb_pkg::result_t out_data
);

  fnb_pkg::result_t q [fnb_pkg::OUTQ_DEPTH];
  logic [1:0]       head;
  logic [1:0]       tail;
  logic [1:0]       cnt;
  logic             pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(fnb_pkg::OUTQ_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_data  = q[head];
  // room for the item in the compute stage plus one more
  assign space     = ({1'b0, cnt} + {2'b00, inflight}) <= 3'(fnb_pkg::OUTQ_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/inplace_four_neighbour_blur_top.sv @@
// ============================================================================
// inplace_four_neighbour_blur_top
// Streaming in-place four-neighbor blur over a raster pixel stream.
// ============================================================================
// Throughput: one pixel transfer per cycle, sustained, while results are taken.
// Result path: a result is registered in the compute stage, then written to the
//   result queue before it is offered; output row r needs input row r+1.
// Reset: synchronous, active high; clears the raster position, the result
//   queue and the last blurred pixel, and loads width 320 and height 200.
// Line memories are not cleared; no unwritten entry feeds a result.
module inplace_four_neighbour_blur_top (
  input  logic      clk,
  input  logic      rst,
  fnb_pix_if.sink   pix,
  fnb_res_if.source res,
  fnb_cfg_if.sink   cfg
);

  fnb_pkg::item_ctl_t ctl;
  fnb_pkg::result_t   core_result;
  fnb_pkg::result_t   q_result;
  logic               accept;
  logic               space;
  logic               busy;
  logic               push;
  logic               cfg_we;

  // Register writes are always taken; the user must send them only while idle, as the block does not enforce it.
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  // Take a pixel whenever the queue can absorb everything in flight.
  assign pix.ready = space;
  assign accept    = pix.valid && space;

  // Position tracking: hold the row/column, advance on each pixel transfer.
  fnb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg.index),
    .cfg_data (cfg.data),
    .accept   (accept),
    .ctl      (ctl)
  );

  // Read both line memories at transfer, average and write back next cycle.
  fnb_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pixel  (pix.pixel_in),
    .ctl    (ctl),
    .busy   (busy),
    .push   (push),
    .result (core_result)
  );

  // Queue results so a stalled sink never holds up the compute stage.
  fnb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (core_result),
    .inflight  (busy),
    .space     (space),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (q_result)
  );

  assign res.pixel_out = q_result.pixel;
  assign res.frame_end = q_result.frame_end;

endmodule

@@ rtl/fnb_checker.sv @@
// ============================================================================
// fnb_checker
// Port-level checks for the blur block, bound to the top level.
// ============================================================================
module fnb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pix_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [fnb_pkg::PIX_W-1:0] res_pixel_out,
  input logic                      res_frame_end
);

  // A stalled result holds its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_pixel_out)
      && $stable(res_frame_end))
    else $error("result changed while stalled");

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered right after reset");

  // With nothing waiting at the output, the input side must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pix_ready)
    else $error("input stalled with empty output");

  // The frame ends on the bottom row, which is all zero.
  a_frame_end_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_frame_end |-> res_pixel_out == '0)
    else $error("last pixel of frame not zero");

endmodule

bind inplace_four_neighbour_blur_top fnb_checker u_fnb_checker (
  .clk           (clk),
  .rst           (rst),
  .pix_ready     (pix.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_pixel_out (res.pixel_out),
  .res_frame_end (res.frame_end)
);

@@ sim/tb_inplace_four_neighbour_blur_top.sv @@
// ============================================================================
// tb_inplace_four_neighbour_blur_top
// Self-checking bench for the streaming in-place four-neighbor blur. A local
// line-buffer predictor tracks every pixel transfer and queues the blurred
// pixels it expects. A checker compares each result transfer, field by field,
// against the oldest queued pixel. Directed frames come first, then frames at
// the size extremes, then random frames, with bursty input and a stalling
// output.
// ============================================================================
module tb_inplace_four_neighbour_blur_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD     = 20;
  localparam int unsigned RANDOM_ITEMS   = 250;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
  localparam int unsigned MAX_REPORTS    = 10;

  // Output-side stall styles, rotated at random
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_CHOKED} sink_mode_t;

  logic clk = 1'b0;
  logic rst;

  fnb_pix_if pix_ch ();
  fnb_res_if res_ch ();
  fnb_cfg_if cfg_ch ();

  inplace_four_neighbour_blur_top dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers, raster position and
  // both line buffers. Updated only at transfer edges.
  // --------------------------------------------------------------------------
  logic [fnb_pkg::DIM_W-1:0] width_reg;
  logic [fnb_pkg::DIM_W-1:0] height_reg;
  int unsigned               raster_pos;
  logic [fnb_pkg::PIX_W-1:0] raw_line  [fnb_pkg::MAX_WIDTH];
  logic [fnb_pkg::PIX_W-1:0] blur_line [fnb_pkg::MAX_WIDTH];
  logic [fnb_pkg::PIX_W-1:0] last_blur;

  fnb_pkg::result_t blur_expect_q[$];
  fnb_pkg::result_t want;
  int unsigned error_count  = 0;
  int unsigned pixels_sent  = 0;
  int unsigned burst_left   = 0;

  sink_mode_t  sink_mode    = SINK_OPEN;
  int unsigned sink_hold    = 0;
  int unsigned sink_tick    = 0;

  // Out-of-range sizes fall back to the nearest legal one
  function automatic int unsigned eff_dim(input logic [fnb_pkg::DIM_W-1:0] v,
                                          input int unsigned hi);
    if (v < 2) return 2;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // Advance the raster position by one input pixel and queue the blurred
  // pixel it releases, if any. Row 0 only fills the raw line buffer.
  function automatic void predict_blur(input logic [fnb_pkg::PIX_W-1:0] px);
    int unsigned w, h, row, col, last_pos, right_px, sum;
    logic [fnb_pkg::PIX_W-1:0] blurred;
    fnb_pkg::result_t r;
    w        = eff_dim(width_reg, fnb_pkg::MAX_WIDTH);
    h        = eff_dim(height_reg, fnb_pkg::MAX_HEIGHT);
    row      = raster_pos / w;
    col      = raster_pos % w;
    last_pos = (h + 1) * w - 1;
    if (row >= 1) begin
      blurred = '0;
      // top and bottom output rows stay zero
      if (row - 1 != 0 && row - 1 != h - 1) begin
        // right neighbor wraps onto the next row's first raw pixel
        right_px = (col + 1 < w) ? 32'(raw_line[fnb_pkg::COL_W'(col + 1)])
                                 : 32'(raw_line[0]);
        sum      = 32'(last_blur) + right_px + 32'(blur_line[fnb_pkg::COL_W'(col)])
                 + 32'(px);
        blurred  = fnb_pkg::PIX_W'(sum >> fnb_pkg::AVG_SHIFT);
      end
      blur_line[fnb_pkg::COL_W'(col)] = blurred;
      last_blur      = blurred;
      r.pixel        = blurred;
      r.frame_end    = (raster_pos >= last_pos);
      blur_expect_q.push_back(r);
    end
    raw_line[fnb_pkg::COL_W'(col)] = px;
    raster_pos    = (raster_pos >= last_pos) ? 0 : raster_pos + 1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one pixel and hold it until transferred. Between bursts, drop valid
  // for a random gap and put noise on the data lines.
  task automatic send_pixel(input logic [fnb_pkg::PIX_W-1:0] px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_ch.valid    <= 1'b0;
        pix_ch.pixel_in <= fnb_pkg::PIX_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_ch.valid    <= 1'b1;
    pix_ch.pixel_in <= px;
    do @(posedge clk); while (!pix_ch.ready);
    predict_blur(px);
    pixels_sent++;
  endtask

  // Random pixels; now and then hold the stream until the output drains
  task automatic send_random_pixels(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 399) == 0) settle();
      send_pixel(fnb_pkg::PIX_W'($urandom));
    end
  endtask

  // Drop valid, wait for every queued result, then let row-0 work finish
  task automatic settle();
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; mirror it into the predictor at the transfer edge
  task automatic write_reg(input logic [fnb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fnb_pkg::DIM_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == fnb_pkg::REG_LINE_WIDTH) begin
      width_reg  = value;
      raster_pos = 0;
    end else if (idx == fnb_pkg::REG_FRAME_HEIGHT) begin
      height_reg = value;
      raster_pos = 0;
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small sizes, sometimes the illegal low codes, sometimes wider
  function automatic logic [fnb_pkg::DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return fnb_pkg::DIM_W'($urandom_range(0, 1));
      1:       return fnb_pkg::DIM_W'($urandom_range(17, 40));
      default: return fnb_pkg::DIM_W'($urandom_range(2, 16));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // 3x3 frame plus a padding row: zero top and bottom rows, wrap on both
  // sides of the middle row, frame end on the last padding transfer
  task automatic test_small_frame();
    logic [fnb_pkg::PIX_W-1:0] frame_px [12];
    frame_px = '{8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'h00, 8'hFF,
                 8'h00, 8'hFF, 8'h00,
                 8'hA5, 8'h5A, 8'hFF};
    write_reg(fnb_pkg::REG_LINE_WIDTH, fnb_pkg::DIM_W'(3));
    write_reg(fnb_pkg::REG_FRAME_HEIGHT, fnb_pkg::DIM_W'(3));
    foreach (frame_px[i]) send_pixel(frame_px[i]);
    settle();
  endtask

  // Width 0 and height 1 both act as 2. A write past the register list in the
  // middle of the frame must not restart it.
  task automatic test_clamp_and_ignored_index();
    write_reg(fnb_pkg::REG_LINE_WIDTH, fnb_pkg::DIM_W'(0));
    write_reg(fnb_pkg::REG_FRAME_HEIGHT, fnb_pkg::DIM_W'(1));
    repeat (3) send_pixel(8'hFF);
    settle();
    write_reg(fnb_pkg::CFG_IDX_W'(255), fnb_pkg::DIM_W'(1023));
    write_reg(fnb_pkg::CFG_IDX_W'(2), fnb_pkg::DIM_W'(0));
    repeat (3) send_pixel(8'h00);
    settle();
  endtask

  // Rewriting a register with its own value mid-frame restarts the frame
  task automatic test_frame_restart();
    write_reg(fnb_pkg::REG_LINE_WIDTH, fnb_pkg::DIM_W'(2));
    write_reg(fnb_pkg::REG_FRAME_HEIGHT, fnb_pkg::DIM_W'(2));
    send_random_pixels(3);
    settle();
    write_reg(fnb_pkg::REG_FRAME_HEIGHT, fnb_pkg::DIM_W'(2));
    send_random_pixels(6);
    settle();
  endtask

  // Oversize width code: the first result must come from the 513th pixel.
  // Oversize height code: a full frame of 512 rows plus padding.
  task automatic test_extreme_sizes();
    write_reg(fnb_pkg::REG_LINE_WIDTH, fnb_pkg::DIM_W'(1023));
    write_reg(fnb_pkg::REG_FRAME_HEIGHT, fnb_pkg::DIM_W'(0));
    send_random_pixels(fnb_pkg::MAX_WIDTH + 4);
    settle();
    write_reg(fnb_pkg::REG_LINE_WIDTH, fnb_pkg::DIM_W'(2));
    write_reg(fnb_pkg::REG_FRAME_HEIGHT, fnb_pkg::DIM_W'(1023));
    send_random_pixels((fnb_pkg::MAX_HEIGHT + 1) * 2);
    settle();
  endtask

  // Random sizes, mostly whole frames; some frames are cut short by the next
  // register write
  task automatic test_random_frames();
    int unsigned start_count, frame_items, frames, remaining, count;
    logic [fnb_pkg::DIM_W-1:0] w_val, h_val;
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      settle();
      w_val = pick_dim();
      h_val = pick_dim();
      if ($urandom_range(0, 1) == 1) begin
        write_reg(fnb_pkg::REG_LINE_WIDTH, w_val);
        write_reg(fnb_pkg::REG_FRAME_HEIGHT, h_val);
      end else begin
        write_reg(fnb_pkg::REG_FRAME_HEIGHT, h_val);
        write_reg(fnb_pkg::REG_LINE_WIDTH, w_val);
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(fnb_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                  fnb_pkg::DIM_W'($urandom));
      frame_items = (eff_dim(height_reg, fnb_pkg::MAX_HEIGHT) + 1) *
                    eff_dim(width_reg, fnb_pkg::MAX_WIDTH);
      frames      = (frame_items > 100) ? 1 : $urandom_range(1, 3);
      count       = frames * frame_items;
      if ($urandom_range(0, 4) == 0)
        count = count - $urandom_range(1, frame_items - 1);
      // keep the run near its item budget; a clipped frame ends early
      remaining = RANDOM_ITEMS - (pixels_sent - start_count);
      if (count > remaining) count = remaining;
      send_random_pixels(count);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: rotate through stall styles so stalls land on every phase
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_hold == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_hold = $urandom_range(16, 160);
    end
    sink_hold--;
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:     res_ch.ready <= 1'b1;
      SINK_COIN:     res_ch.ready <= ($urandom_range(0, 1) == 1);
      SINK_PERIODIC: res_ch.ready <= (sink_tick % 4 != 3);
      default:       res_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Check each result transfer against the oldest queued pixel
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (blur_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: pixel %0d frame_end %0b",
                   $realtime, res_ch.pixel_out, res_ch.frame_end);
      end else begin
        want = blur_expect_q.pop_front();
        if (res_ch.pixel_out !== want.pixel || res_ch.frame_end !== want.frame_end) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: pixel exp %0d got %0d, frame_end exp %0b got %0b",
                     $realtime, want.pixel, res_ch.pixel_out,
                     want.frame_end, res_ch.frame_end);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_inplace_four_neighbour_blur_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // drive every input to a known value before the first edge
    rst             = 1'b1;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    res_ch.ready    = 1'b0;

    // predictor takes its reset values
    width_reg  = fnb_pkg::LINE_WIDTH_RST;
    height_reg = fnb_pkg::FRAME_HEIGHT_RST;
    raster_pos = 0;
    last_blur  = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_small_frame();
    test_clamp_and_ignored_index();
    test_frame_restart();
    test_extreme_sizes();
    test_random_frames();

    // wait out the last results, then report
    settle();
    if (error_count == 0 && blur_expect_q.size() == 0) begin
      $display("tb_inplace_four_neighbour_blur_top: done, clean");
    end else begin
      $display("tb_inplace_four_neighbour_blur_top: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fnb_pkg.sv
rtl/fnb_ifs.sv
rtl/fnb_ctrl.sv
rtl/fnb_core.sv
rtl/fnb_outq.sv
rtl/inplace_four_neighbour_blur_top.sv
rtl/fnb_checker.sv
sim/tb_inplace_four_neighbour_blur_top.sv
